FILE: design/sgrt_pkg.sv
// Shared types and constants for the state group restore tracker.
package sgrt_pkg;

  localparam int OP_W = 4;
  localparam int IDX_W = 6;
  localparam int GID_W = 16;
  localparam int ACTIVE_W = 7;
  localparam int MASK_W = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN         = 4'd0,
    OP_JOIN          = 4'd1,
    OP_FORCE_RESET   = 4'd2,
    OP_IS_CURRENT    = 4'd3,
    OP_RESTORE_GROUP = 4'd4,
    OP_PRIOR         = 4'd5,
    OP_SUBSEQUENT    = 4'd6,
    OP_ALL           = 4'd7,
    OP_ONE           = 4'd8,
    OP_FORCE_ONE     = 4'd9,
    OP_TEX           = 4'd10,
    OP_FORCE_TEX     = 4'd11
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ACTIVE_STATES = 2'd0,
    REG_HANDLER_MASK  = 2'd1,
    REG_TEXTURE_FIRST = 2'd2,
    REG_TEXTURE_LAST  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] state_index;
    logic [GID_W-1:0] group_id;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] reset_index;
    logic             reset_fire;
    logic [GID_W-1:0] group_value;
    logic             is_current;
    logic             last;
  } rsp_t;

  typedef struct packed {
    op_t              op;
    logic             en;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic             step;
    logic             clear_all;
  } cell_ctl_t;

  typedef struct packed {
    logic fire;
    logic hit;
  } cell_stat_t;

endpackage

FILE: design/sgrt_if.sv
// Valid/ready channel interfaces for request and result beats.
interface sgrt_req_if;
  logic          valid;
  logic          ready;
  sgrt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sgrt_rsp_if;
  logic          valid;
  logic          ready;
  sgrt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/sgrt_cell.sv
// One tracker cell: holds a state's group tag and passes the scan token on.
module sgrt_cell #(
  parameter int GROUP_BITS = 16,
  parameter int CELL_INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sgrt_pkg::cell_ctl_t   ctl,
  input  logic [GROUP_BITS-1:0] g,
  input  logic [GROUP_BITS-1:0] cur,
  input  logic                  has_handler,
  input  logic                  tok_in,
  output logic                  tok,
  output sgrt_pkg::cell_stat_t  stat
);

  localparam logic [GROUP_BITS-1:0] ONES = '1;
  localparam logic [sgrt_pkg::IDX_W-1:0] MY_IDX = sgrt_pkg::IDX_W'(CELL_INDEX);

  logic [GROUP_BITS-1:0] tag;
  logic [GROUP_BITS-1:0] tag_next;
  logic                  act;
  logic                  sel;

  assign act = tok & ctl.step & ctl.en & (MY_IDX >= ctl.lo) & (MY_IDX <= ctl.hi);

  always_comb begin
    unique case (ctl.op) inside
      sgrt_pkg::OP_RESTORE_GROUP: sel = (tag == g) || (tag == ONES);
      sgrt_pkg::OP_PRIOR:         sel = (tag != '0) && ((tag < g) || (tag == ONES));
      sgrt_pkg::OP_SUBSEQUENT:    sel = (tag > g) || (tag == ONES);
      sgrt_pkg::OP_ALL, sgrt_pkg::OP_ONE, sgrt_pkg::OP_TEX: sel = (tag != '0);
      sgrt_pkg::OP_FORCE_ONE, sgrt_pkg::OP_FORCE_TEX:       sel = 1'b1;
      default:                    sel = 1'b0;
    endcase
  end

  always_comb begin
    tag_next = tag;
    if (ctl.clear_all) begin
      tag_next = '0;
    end else if (act) begin
      if (ctl.op == sgrt_pkg::OP_JOIN) begin
        tag_next = cur;
      end else if (ctl.op == sgrt_pkg::OP_FORCE_RESET) begin
        tag_next = ONES;
      end else if (sel) begin
        tag_next = '0;
      end
    end
  end

  assign stat.fire = act & sel & has_handler;
  assign stat.hit  = act & (ctl.op == sgrt_pkg::OP_IS_CURRENT) & (tag == cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
      tok <= 1'b0;
    end else begin
      tag <= tag_next;
      if (ctl.step) begin
        tok <= tok_in;
      end
    end
  end

endmodule

FILE: design/state_group_restore_tracker.sv
// Top level of the state group restore tracker: controller, registers and the cell chain.
// Begin and undefined ops skip the scan and give their single beat from the final state.
// All other ops walk a token down all NUM_STATES cells, one cell per cycle while the output
// register is empty or its result is taken; result stalls pause the walk.
// A new request is taken only once the previous item's last beat is in the output register.
// Synchronous reset clears every tag, the group counter and the config registers but active_states.
module state_group_restore_tracker #(
  parameter int NUM_STATES = 64,
  parameter int GROUP_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  sgrt_req_if.sink                            req,
  sgrt_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [sgrt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sgrt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDXW = $clog2(NUM_STATES);
  localparam logic [GROUP_BITS-1:0] ONES = '1;
  localparam logic [GROUP_BITS-1:0] TOP = {{(GROUP_BITS-1){1'b1}}, 1'b0};
  localparam logic [sgrt_pkg::ACTIVE_W-1:0] NUM_A = sgrt_pkg::ACTIVE_W'(NUM_STATES);
  localparam logic [IDXW-1:0] LAST_POS = IDXW'(NUM_STATES - 1);
  localparam logic [sgrt_pkg::IDX_W-1:0] LAST_IDX = sgrt_pkg::IDX_W'(NUM_STATES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                          state;
  logic [sgrt_pkg::ACTIVE_W-1:0]   active_states;
  logic [sgrt_pkg::MASK_W-1:0]     handler_mask;
  logic [sgrt_pkg::IDX_W-1:0]      texture_first;
  logic [sgrt_pkg::IDX_W-1:0]      texture_last;
  logic [GROUP_BITS-1:0]           current_group;
  logic [GROUP_BITS-1:0]           cmd_g;
  sgrt_pkg::op_t                   cmd_op;
  logic                            cmd_en;
  logic [sgrt_pkg::IDX_W-1:0]      cmd_lo;
  logic [sgrt_pkg::IDX_W-1:0]      cmd_hi;
  logic [IDXW-1:0]                 pos;
  logic                            pend_v;
  logic [IDXW-1:0]                 pend_idx;
  logic                            hit;
  logic                            ov;
  sgrt_pkg::rsp_t                  od;

  logic                            accept;
  logic                            start;
  logic                            can_push;
  logic                            scan_step;
  logic                            scan_end;
  logic                            clear_all;
  logic                            push_mid;
  logic                            fin_push;
  logic                            fire_any;
  logic                            hit_any;
  logic [47:0]                     gid_ext;
  logic [47:0]                     cur_ext;
  logic [sgrt_pkg::GID_W-1:0]      gv;
  logic [sgrt_pkg::ACTIVE_W-1:0]   n_scan;
  logic                            walk;
  logic                            en_new;
  logic [sgrt_pkg::IDX_W-1:0]      lo_new;
  logic [sgrt_pkg::IDX_W-1:0]      hi_new;
  logic [NUM_STATES-1:0]           tok;
  logic [NUM_STATES-1:0]           fire_vec;
  logic [NUM_STATES-1:0]           hit_vec;
  sgrt_pkg::cell_ctl_t             ctl;
  sgrt_pkg::op_t                   req_op;

  assign req_op   = sgrt_pkg::op_t'(req.data.op);
  assign req.ready = (state == ST_IDLE);
  assign accept   = req.valid & req.ready;
  assign can_push = ~ov | rsp.ready;
  assign scan_step = (state == ST_SCAN) & can_push;
  assign scan_end  = scan_step & (pos == LAST_POS);
  assign clear_all = scan_end & (cmd_op == sgrt_pkg::OP_ALL);
  assign fire_any  = |fire_vec;
  assign hit_any   = |hit_vec;
  assign push_mid  = scan_step & fire_any & pend_v;
  assign fin_push  = (state == ST_FIN) & can_push;

  assign gid_ext = {32'd0, req.data.group_id};
  assign cur_ext = {{(48 - GROUP_BITS){1'b0}}, current_group};
  assign gv      = cur_ext[sgrt_pkg::GID_W-1:0];
  assign n_scan  = (active_states > NUM_A) ? NUM_A : active_states;

  always_comb begin
    walk   = 1'b1;
    en_new = 1'b0;
    lo_new = req.data.state_index;
    hi_new = req.data.state_index;
    unique case (req_op) inside
      sgrt_pkg::OP_JOIN, sgrt_pkg::OP_FORCE_RESET, sgrt_pkg::OP_IS_CURRENT,
      sgrt_pkg::OP_ONE, sgrt_pkg::OP_FORCE_ONE: begin
        en_new = ({1'b0, req.data.state_index} < NUM_A);
      end
      sgrt_pkg::OP_RESTORE_GROUP, sgrt_pkg::OP_PRIOR, sgrt_pkg::OP_SUBSEQUENT,
      sgrt_pkg::OP_ALL: begin
        en_new = (n_scan != '0);
        lo_new = '0;
        hi_new = sgrt_pkg::IDX_W'(n_scan - 7'd1);
      end
      sgrt_pkg::OP_TEX, sgrt_pkg::OP_FORCE_TEX: begin
        en_new = (texture_first <= texture_last) && ({1'b0, texture_first} < NUM_A);
        lo_new = texture_first;
        hi_new = ({1'b0, texture_last} >= NUM_A) ? LAST_IDX : texture_last;
      end
      default: begin
        walk = 1'b0;
      end
    endcase
  end

  assign start = accept & walk;

  assign ctl.op        = cmd_op;
  assign ctl.en        = cmd_en;
  assign ctl.lo        = cmd_lo;
  assign ctl.hi        = cmd_hi;
  assign ctl.step      = scan_step | start;
  assign ctl.clear_all = clear_all;

  for (genvar i = 0; i < NUM_STATES; i++) begin : g_cell
    sgrt_pkg::cell_stat_t stat;

    sgrt_cell #(
      .GROUP_BITS (GROUP_BITS),
      .CELL_INDEX (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .g           (cmd_g),
      .cur         (current_group),
      .has_handler (handler_mask[i]),
      .tok_in      ((i == 0) ? start : tok[(i == 0) ? 0 : i - 1]),
      .tok         (tok[i]),
      .stat        (stat)
    );

    assign fire_vec[i] = stat.fire;
    assign hit_vec[i]  = stat.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_states <= NUM_A;
      handler_mask  <= '0;
      texture_first <= '0;
      texture_last  <= '0;
    end else if (cfg_we) begin
      unique case (sgrt_pkg::cfg_reg_t'(cfg_addr))
        sgrt_pkg::REG_ACTIVE_STATES: active_states <= cfg_data[sgrt_pkg::ACTIVE_W-1:0];
        sgrt_pkg::REG_HANDLER_MASK:  handler_mask  <= cfg_data[sgrt_pkg::MASK_W-1:0];
        sgrt_pkg::REG_TEXTURE_FIRST: texture_first <= cfg_data[sgrt_pkg::IDX_W-1:0];
        sgrt_pkg::REG_TEXTURE_LAST:  texture_last  <= cfg_data[sgrt_pkg::IDX_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_group <= '0;
      pos           <= '0;
      pend_v        <= 1'b0;
      hit           <= 1'b0;
      ov            <= 1'b0;
    end else begin
      ov <= (ov & ~rsp.ready) | push_mid | fin_push;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pos    <= '0;
            pend_v <= 1'b0;
            hit    <= 1'b0;
            state  <= walk ? ST_SCAN : ST_FIN;
            if (req_op == sgrt_pkg::OP_BEGIN && current_group < TOP) begin
              current_group <= current_group + 1'b1;
            end else if (req_op == sgrt_pkg::OP_ALL) begin
              current_group <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_step) begin
            pos <= pos + 1'b1;
            if (fire_any) begin
              pend_v <= 1'b1;
            end
            if (hit_any) begin
              hit <= 1'b1;
            end
            if (scan_end) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (fin_push) begin
            pend_v <= 1'b0;
            hit    <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op <= req_op;
      cmd_en <= en_new;
      cmd_lo <= lo_new;
      cmd_hi <= hi_new;
      cmd_g  <= gid_ext[GROUP_BITS-1:0];
    end
    if (scan_step && fire_any) begin
      pend_idx <= pos;
    end
    if (push_mid) begin
      od.reset_index <= sgrt_pkg::IDX_W'(pend_idx);
      od.reset_fire  <= 1'b1;
      od.group_value <= gv;
      od.is_current  <= 1'b0;
      od.last        <= 1'b0;
    end else if (fin_push) begin
      od.reset_index <= pend_v ? sgrt_pkg::IDX_W'(pend_idx) : '0;
      od.reset_fire  <= pend_v;
      od.group_value <= gv;
      od.is_current  <= pend_v ? 1'b0 : hit;
      od.last        <= 1'b1;
    end
  end

  assign rsp.valid = ov;
  assign rsp.data  = od;

`ifndef ASSERT_OFF
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_v)
    else $error("pending reset order left over while idle");

  a_token_at_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ($onehot(tok) && tok[pos]))
    else $error("scan token is not at the scan position");

  a_no_stray_token: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (tok == '0))
    else $error("scan token present outside a scan");

  a_group_below_marker: assert property (@(posedge clk) disable iff (rst)
    current_group != ONES)
    else $error("group counter reached the reset marker");

  a_end_to_finish: assert property (@(posedge clk) disable iff (rst)
    scan_end |=> (state == ST_FIN))
    else $error("scan end did not lead to the final beat");
`endif

endmodule
